[sv/mrc_pkg.sv]
package mrc_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0] FUNC_EXC_BIT = 8'h80;
    localparam logic [8:0] MIN_FRAME_LEN = 9'd5;
    // first payload position (after slave, function and count bytes)
    localparam logic [9:0] PAYLOAD_START = 10'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_CRC_ERR    = 2'd1,
        ST_FORMAT_ERR = 2'd2,
        ST_EXCEPTION  = 2'd3
    } t_status;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // everything one accepted byte causes at the output
    typedef struct packed {
        logic       has_pay;
        logic       has_status;
        logic [7:0] pay_byte;
        t_status    status;
        logic [7:0] exc_code;
        logic [7:0] slave;
        logic [7:0] func;
        logic [7:0] count;
        logic [8:0] len;
        logic [15:0] rcrc;
    } t_rec;

    function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[sv/mrc_front.sv]
module mrc_front #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_eof,
    output logic          o_push,
    output mrc_pkg::t_rec o_rec,
    input  logic          i_full
);
    import mrc_pkg::*;

    localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME_BYTES);

    logic [15:0] r_crc, n_crc;
    logic [8:0]  r_idx, n_idx;
    logic [7:0]  r_d0, n_d0, r_d1, n_d1;
    logic [7:0]  r_slave, n_slave, r_func, n_func, r_count, n_count;

    logic [15:0] crc_fed;
    logic [15:0] rcrc;
    logic [8:0]  len;
    logic        feed;
    logic        pay;
    logic        accept;
    t_status     st;

    assign o_ready = !i_full;
    assign accept = i_valid && o_ready;
    // only bytes that cause a result go into the queue
    assign o_push = accept && (pay || i_eof);

    always_comb begin
        n_slave = (r_idx == 9'd0) ? i_byte : r_slave;
        n_func  = (r_idx == 9'd1) ? i_byte : r_func;
        n_count = (r_idx == 9'd2) ? i_byte : r_count;

        // oldest byte of the delay line enters the crc once two bytes are held back
        feed = (r_idx >= 9'd2);
        crc_fed = feed ? crc_feed(r_crc, r_d1) : r_crc;
        pay = feed && (r_idx < MAX_LEN)
            && ({1'b0, r_idx} >= PAYLOAD_START + 10'd2)
            && ({1'b0, r_idx} < PAYLOAD_START + 10'd2 + {2'b00, n_count});

        len = (r_idx == MAX_LEN) ? MAX_LEN : r_idx + 9'd1;
        rcrc = {i_byte, (r_idx >= 9'd1) ? r_d0 : 8'h00};

        if ((len < MIN_FRAME_LEN) || (crc_fed != rcrc)) begin
            st = ST_CRC_ERR;
        end else if (len == MIN_FRAME_LEN) begin
            st = ((n_func & FUNC_EXC_BIT) == 8'h00) ? ST_FORMAT_ERR : ST_EXCEPTION;
        end else begin
            st = ST_OK;
        end

        o_rec.has_pay    = pay;
        o_rec.has_status = i_eof;
        o_rec.pay_byte   = r_d1;
        o_rec.status     = st;
        o_rec.exc_code   = (st == ST_EXCEPTION) ? n_count : 8'h00;
        o_rec.slave      = n_slave;
        o_rec.func       = n_func;
        o_rec.count      = n_count;
        o_rec.len        = len;
        o_rec.rcrc       = rcrc;

        n_crc = r_crc;
        n_idx = r_idx;
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (accept) begin
            if (i_eof) begin
                n_crc = CRC_INIT;
                n_idx = 9'd0;
                n_d0 = 8'h00;
                n_d1 = 8'h00;
                n_slave = 8'h00;
                n_func = 8'h00;
                n_count = 8'h00;
            end else begin
                n_crc = crc_fed;
                n_idx = (r_idx < MAX_LEN) ? r_idx + 9'd1 : r_idx;
                n_d1 = r_d0;
                n_d0 = i_byte;
            end
        end else begin
            n_slave = r_slave;
            n_func = r_func;
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
            r_idx <= 9'd0;
            r_d0 <= 8'h00;
            r_d1 <= 8'h00;
            r_slave <= 8'h00;
            r_func <= 8'h00;
            r_count <= 8'h00;
        end else begin
            r_crc <= n_crc;
            r_idx <= n_idx;
            r_d0 <= n_d0;
            r_d1 <= n_d1;
            r_slave <= n_slave;
            r_func <= n_func;
            r_count <= n_count;
        end
    end

endmodule

[sv/mrc_queue.sv]
module mrc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mrc_pkg::t_rec i_rec,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mrc_pkg::t_rec o_rec
);
    import mrc_pkg::*;

    t_rec r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[sv/mrc_back.sv]
module mrc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  mrc_pkg::t_rec i_rec,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_kind,
    output logic          o_last,
    output logic [7:0]    o_data_byte,
    output logic [1:0]    o_status,
    output logic [7:0]    o_exc,
    output logic [7:0]    o_slave,
    output logic [7:0]    o_func,
    output logic [7:0]    o_count,
    output logic [8:0]    o_len,
    output logic [15:0]   o_rcrc
);
    import mrc_pkg::*;

    logic r_valid;
    logic r_second;    // payload of a two-result item already sent
    logic r_kind, r_last;
    logic [7:0] r_data, r_exc, r_slave, r_func, r_count;
    logic [1:0] r_status;
    logic [8:0] r_len;
    logic [15:0] r_rcrc;

    logic load;
    logic send_status;

    assign load = !i_empty && (!r_valid || i_ready);
    assign send_status = r_second || !i_rec.has_pay;
    // two-result items stay at the head until their status result is loaded
    assign o_pop = load && (send_status || !i_rec.has_status);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_second <= !o_pop;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (send_status) begin
                r_kind <= KIND_STATUS;
                r_last <= 1'b1;
                r_data <= 8'h00;
                r_status <= i_rec.status;
                r_exc <= i_rec.exc_code;
                r_slave <= i_rec.slave;
                r_func <= i_rec.func;
                r_count <= i_rec.count;
                r_len <= i_rec.len;
                r_rcrc <= i_rec.rcrc;
            end else begin
                r_kind <= KIND_PAYLOAD;
                r_last <= !i_rec.has_status;
                r_data <= i_rec.pay_byte;
                r_status <= ST_OK;
                r_exc <= 8'h00;
                r_slave <= 8'h00;
                r_func <= 8'h00;
                r_count <= 8'h00;
                r_len <= 9'd0;
                r_rcrc <= 16'h0000;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_last = r_last;
    assign o_data_byte = r_data;
    assign o_status = r_status;
    assign o_exc = r_exc;
    assign o_slave = r_slave;
    assign o_func = r_func;
    assign o_count = r_count;
    assign o_len = r_len;
    assign o_rcrc = r_rcrc;

endmodule

[sv/modbus_rtu_response_checker_top.sv]
// channel   dir  tdata                              tuser        tlast
// s_axis    in   [7:0] rx_byte                      -            end_of_frame
// m_axis    out  payload byte / frame status, 72b   result_kind  final_result
//
// one byte accepted per cycle unless queue is full; its crc is one unrolled step
// a last byte that also releases a payload byte yields two items on m_axis, one
// after the other; a four-entry queue between front and back absorbs that
// a result is written to the queue, then loaded into the back end's output register
// synchronous active-low reset returns the crc, delay line and header to idle
// s_axis_tready drops only while the queue is full
module modbus_rtu_response_checker_top #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [9:8] status, [17:10] exception_code, [25:18] slave_address,
    // [33:26] reply_function, [41:34] payload_count, [50:42] frame_length,
    // [66:51] received_crc, [71:67] zero
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] result_kind
    output logic        m_axis_tlast
);
    import mrc_pkg::*;

    t_rec front_rec, head_rec;
    logic push, full, pop, empty;
    logic [7:0] data_byte, exc, slave, func, count;
    logic [1:0] status;
    logic [8:0] len;
    logic [15:0] rcrc;

    mrc_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata),
        .i_eof(s_axis_tlast),
        .o_push(push),
        .o_rec(front_rec),
        .i_full(full)
    );

    mrc_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_rec(front_rec),
        .o_full(full),
        .i_pop(pop),
        .o_empty(empty),
        .o_rec(head_rec)
    );

    mrc_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_rec(head_rec),
        .o_pop(pop),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_kind(m_axis_tuser),
        .o_last(m_axis_tlast),
        .o_data_byte(data_byte),
        .o_status(status),
        .o_exc(exc),
        .o_slave(slave),
        .o_func(func),
        .o_count(count),
        .o_len(len),
        .o_rcrc(rcrc)
    );

    assign m_axis_tdata = {5'b00000, rcrc, len, count, func, slave, exc, status, data_byte};

endmodule
